// ----- hdl/bdcl_pkg.sv -----
// ----------------------------------------------------------------------------
// bdcl_pkg
// Shared types, constants and the open-circuit voltage table of the battery
// discharge current limit unit.
// ----------------------------------------------------------------------------
package bdcl_pkg;

  // physical port slots on the channel, and how many of them are evaluated
  localparam int PortSlots = 3;
  localparam int PortCount = 3;

  localparam int SocW     = 7;
  localparam int TempW    = 8;
  localparam int LimitW   = 16;
  localparam int CountW   = 2;

  localparam int OcvEntries = 101;
  localparam int OcvW       = 17;
  localparam int OcvBase    = 53000;
  localparam int DiffW      = 14;

  // 1000/R expressed as k/d: 150 -> 20/3, 90 -> 100/9, 60 -> 50/3
  // division by d is a multiply by a rounded-up reciprocal, exact for our range
  localparam int RecipShift = 24;
  localparam int RecipThird = ((1 << RecipShift) + 2) / 3;
  localparam int RecipNinth = ((1 << RecipShift) + 8) / 9;
  localparam int CoefOne    = 20 * RecipThird;
  localparam int CoefTwo    = 100 * RecipNinth;
  localparam int CoefThree  = 50 * RecipThird;
  localparam int CoefW      = 29;
  localparam int ProdW      = DiffW + CoefW;
  localparam int RawW       = 18;
  localparam int LimCalcW   = RawW + 1;

  localparam int SocMin        = 1;
  localparam int SocMax        = 99;
  localparam int LowSocThresh  = 20;
  localparam int LowSocPenalty = 2000;

  localparam int LimOneMin     = 5000;
  localparam int LimOneMax     = 35000;
  localparam int LimTwoMax     = 45000;
  localparam int LimTwoFloor   = 1000;
  localparam int LimTwoSubst   = 10000;
  localparam int LimThreeMin   = 15000;
  localparam int LimThreeMax   = 50000;
  localparam int CapOverheat   = 20000;
  localparam int TempSet       = 55;
  localparam int TempHold      = 54;

  localparam logic [OcvW-1:0] OcvMv [OcvEntries] = '{
    17'd53000, 17'd53000, 17'd53000, 17'd53000, 17'd53000,
    17'd53000, 17'd55114, 17'd55203, 17'd55291, 17'd55371,
    17'd55440, 17'd55520, 17'd55619, 17'd55763, 17'd55962,
    17'd56146, 17'd56512, 17'd56656, 17'd56774, 17'd56890,
    17'd57003, 17'd57112, 17'd57206, 17'd57301, 17'd57381,
    17'd57445, 17'd57525, 17'd57589, 17'd57658, 17'd57723,
    17'd57778, 17'd57827, 17'd57877, 17'd57915, 17'd57960,
    17'd58005, 17'd58050, 17'd58090, 17'd58139, 17'd58179,
    17'd58224, 17'd58278, 17'd58323, 17'd58373, 17'd58422,
    17'd58472, 17'd58531, 17'd58590, 17'd58650, 17'd58715,
    17'd58784, 17'd58858, 17'd58942, 17'd59037, 17'd59155,
    17'd59299, 17'd59469, 17'd59662, 17'd59845, 17'd60010,
    17'd60142, 17'd60272, 17'd60402, 17'd60530, 17'd60659,
    17'd60794, 17'd60931, 17'd61070, 17'd61210, 17'd61349,
    17'd61493, 17'd61642, 17'd61790, 17'd62093, 17'd62246,
    17'd62405, 17'd62563, 17'd62723, 17'd62882, 17'd63050,
    17'd63213, 17'd63378, 17'd63546, 17'd63715, 17'd63883,
    17'd64067, 17'd64245, 17'd64429, 17'd64608, 17'd64800,
    17'd64984, 17'd65173, 17'd65366, 17'd65565, 17'd65763,
    17'd65971, 17'd66179, 17'd66394, 17'd66621, 17'd66854,
    17'd67117
  };

  typedef struct packed {
    logic [PortSlots-1:0]                        discharging;
    logic [PortSlots-1:0][SocW-1:0]              soc;
    logic [PortSlots-1:0][TempW-1:0]             temp;
  } in_item_t;

  typedef struct packed {
    logic [LimitW-1:0] current_limit;
    logic              overheat_active;
  } res_item_t;

  // voltage above the table floor; soc must already be clamped to the table
  function automatic logic [DiffW-1:0] ocv_diff(input logic [SocW-1:0] soc);
    logic [OcvW-1:0] v;
    v = OcvMv[soc];
    return DiffW'(v - OcvW'(OcvBase));
  endfunction

endpackage

// ----- hdl/bdcl_if.sv -----
// ----------------------------------------------------------------------------
// bdcl_in_if / bdcl_out_if
// Valid/ready channels for the port status reports and the current limit.
// ----------------------------------------------------------------------------
interface bdcl_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 discharging_port0;
  logic                                 discharging_port1;
  logic                                 discharging_port2;
  logic        [bdcl_pkg::SocW-1:0]     soc_port0;
  logic        [bdcl_pkg::SocW-1:0]     soc_port1;
  logic        [bdcl_pkg::SocW-1:0]     soc_port2;
  logic signed [bdcl_pkg::TempW-1:0]    temp_port0;
  logic signed [bdcl_pkg::TempW-1:0]    temp_port1;
  logic signed [bdcl_pkg::TempW-1:0]    temp_port2;

  modport source (
    output valid, discharging_port0, discharging_port1, discharging_port2,
           soc_port0, soc_port1, soc_port2, temp_port0, temp_port1, temp_port2,
    input  ready
  );
  modport sink (
    input  valid, discharging_port0, discharging_port1, discharging_port2,
           soc_port0, soc_port1, soc_port2, temp_port0, temp_port1, temp_port2,
    output ready
  );
endinterface

interface bdcl_out_if;
  logic                          valid;
  logic                          ready;
  logic [bdcl_pkg::LimitW-1:0]   current_limit;
  logic                          overheat_active;

  modport source (output valid, current_limit, overheat_active, input ready);
  modport sink   (input  valid, current_limit, overheat_active, output ready);
endinterface

// ----- hdl/battery_discharge_current_limit_unit.sv -----
// ----------------------------------------------------------------------------
// battery_discharge_current_limit_unit
// Derives the allowed bus current from the battery port status reports.
// ----------------------------------------------------------------------------
// path: the input register holds each transaction; the result register takes
//   its result from one pass of table lookup, multiply and clamps
// throughput: one transaction per cycle while the result side keeps taking
// reset: synchronous active-low rst_n empties both stages and clears the
//   over-temperature flag; no clearing pass, ready right after reset
module battery_discharge_current_limit_unit (
  input  logic          clk,
  input  logic          rst_n,
  bdcl_in_if.sink       in_chan,
  bdcl_out_if.source    out_chan
);

  bdcl_pkg::in_item_t  s1_item_r;
  logic                s1_vld_r;
  bdcl_pkg::res_item_t out_item_r;
  logic                out_vld_r;
  logic                out_vld_nxt;
  logic                flag_r;
  bdcl_pkg::res_item_t res;
  logic                advance;
  logic                in_take;

  assign advance = s1_vld_r && (!out_vld_r || out_chan.ready);
  assign in_chan.ready = !s1_vld_r || advance;
  assign in_take = in_chan.valid && in_chan.ready;

  assign out_chan.valid           = out_vld_r;
  assign out_chan.current_limit   = out_item_r.current_limit;
  assign out_chan.overheat_active = out_item_r.overheat_active;

  bdcl_calc u_calc (
    .item   (s1_item_r),
    .flag_r (flag_r),
    .res    (res)
  );

  always_comb begin
    if (advance) begin
      out_vld_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      flag_r    <= 1'b0;
    end else begin
      if (in_take) begin
        s1_vld_r <= 1'b1;
      end else if (advance) begin
        s1_vld_r <= 1'b0;
      end
      out_vld_r <= out_vld_nxt;
      if (advance) begin
        flag_r <= res.overheat_active;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r.discharging <= {in_chan.discharging_port2, in_chan.discharging_port1,
                                in_chan.discharging_port0};
      s1_item_r.soc         <= {in_chan.soc_port2, in_chan.soc_port1, in_chan.soc_port0};
      s1_item_r.temp        <= {in_chan.temp_port2, in_chan.temp_port1,
                                in_chan.temp_port0};
    end
    if (advance) begin
      out_item_r <= res;
    end
  end

  // the limit never exceeds the three-port ceiling
  a_limit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> out_item_r.current_limit <= bdcl_pkg::LimitW'(bdcl_pkg::LimThreeMax))
    else $error("current limit above ceiling");

  // flag state moves only when a transaction passes into the result register
  a_flag_only_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(flag_r))
    else $error("overheat flag changed without a transaction");

  // a full pipeline under a stalled result must not take a new transaction
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && out_vld_r && !out_chan.ready) |-> !in_chan.ready)
    else $error("input taken while both stages are blocked");

  // reported flag matches the state left behind by that transaction
  a_flag_matches: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_item_r.overheat_active == flag_r)
    else $error("reported flag differs from stored flag");

endmodule

// ----- hdl/bdcl_calc.sv -----
// ----------------------------------------------------------------------------
// bdcl_calc
// Current limit datapath: port count, charge lookup, scaling, clamps and the
// single-port over-temperature cap.
// ----------------------------------------------------------------------------
module bdcl_calc (
  input  bdcl_pkg::in_item_t  item,
  input  logic                flag_r,
  output bdcl_pkg::res_item_t res
);

  localparam logic signed [bdcl_pkg::LimCalcW-1:0] PenaltyS =
    bdcl_pkg::LimCalcW'(bdcl_pkg::LowSocPenalty);
  localparam logic signed [bdcl_pkg::LimCalcW-1:0] OneMinS =
    bdcl_pkg::LimCalcW'(bdcl_pkg::LimOneMin);
  localparam logic signed [bdcl_pkg::LimCalcW-1:0] OneMaxS =
    bdcl_pkg::LimCalcW'(bdcl_pkg::LimOneMax);
  localparam logic signed [bdcl_pkg::LimCalcW-1:0] TwoMaxS =
    bdcl_pkg::LimCalcW'(bdcl_pkg::LimTwoMax);
  localparam logic signed [bdcl_pkg::LimCalcW-1:0] TwoFloorS =
    bdcl_pkg::LimCalcW'(bdcl_pkg::LimTwoFloor);
  localparam logic signed [bdcl_pkg::LimCalcW-1:0] TwoSubstS =
    bdcl_pkg::LimCalcW'(bdcl_pkg::LimTwoSubst);
  localparam logic signed [bdcl_pkg::LimCalcW-1:0] ThreeMinS =
    bdcl_pkg::LimCalcW'(bdcl_pkg::LimThreeMin);
  localparam logic signed [bdcl_pkg::LimCalcW-1:0] ThreeMaxS =
    bdcl_pkg::LimCalcW'(bdcl_pkg::LimThreeMax);
  localparam logic signed [bdcl_pkg::LimCalcW-1:0] CapS =
    bdcl_pkg::LimCalcW'(bdcl_pkg::CapOverheat);
  localparam logic signed [bdcl_pkg::TempW-1:0] TempSetS =
    bdcl_pkg::TempW'(bdcl_pkg::TempSet);
  localparam logic signed [bdcl_pkg::TempW-1:0] TempHoldS =
    bdcl_pkg::TempW'(bdcl_pkg::TempHold);

  logic        [bdcl_pkg::CountW-1:0]   count;
  logic        [bdcl_pkg::SocW-1:0]     soc_raw;
  logic        [bdcl_pkg::SocW-1:0]     soc_c;
  logic signed [bdcl_pkg::TempW-1:0]    temp;
  logic        [bdcl_pkg::DiffW-1:0]    diff;
  logic        [bdcl_pkg::CoefW-1:0]    coef;
  logic        [bdcl_pkg::ProdW-1:0]    prod;
  logic signed [bdcl_pkg::LimCalcW-1:0] lim;
  logic signed [bdcl_pkg::LimCalcW-1:0] lim_clip;
  logic signed [bdcl_pkg::LimCalcW-1:0] lim_set;
  logic                                 set_cap;
  logic                                 flag_mid;
  logic                                 keep_cap;

  // count discharging ports; charge from the first, temperature from the last
  always_comb begin
    count   = '0;
    soc_raw = '0;
    temp    = '0;
    for (int i = 0; i < bdcl_pkg::PortCount; i++) begin
      if (item.discharging[i]) begin
        if (count == '0) begin
          soc_raw = item.soc[i];
        end
        temp  = $signed(item.temp[i]);
        count = count + bdcl_pkg::CountW'(1);
      end
    end
  end

  always_comb begin
    if (soc_raw < bdcl_pkg::SocW'(bdcl_pkg::SocMin)) begin
      soc_c = bdcl_pkg::SocW'(bdcl_pkg::SocMin);
    end else if (soc_raw > bdcl_pkg::SocW'(bdcl_pkg::SocMax)) begin
      soc_c = bdcl_pkg::SocW'(bdcl_pkg::SocMax);
    end else begin
      soc_c = soc_raw;
    end
  end

  assign diff = bdcl_pkg::ocv_diff(soc_c);

  always_comb begin
    unique case (count)
      2'd3:    coef = bdcl_pkg::CoefW'(bdcl_pkg::CoefThree);
      2'd2:    coef = bdcl_pkg::CoefW'(bdcl_pkg::CoefTwo);
      default: coef = bdcl_pkg::CoefW'(bdcl_pkg::CoefOne);
    endcase
  end

  // 1000*diff/R as one constant multiply and a shift
  assign prod = bdcl_pkg::ProdW'(diff) * bdcl_pkg::ProdW'(coef);

  always_comb begin
    lim = $signed({1'b0, prod[bdcl_pkg::RecipShift +: bdcl_pkg::RawW]});
    if (count != '0 && soc_c <= bdcl_pkg::SocW'(bdcl_pkg::LowSocThresh)) begin
      lim = lim - PenaltyS;
    end
  end

  // single port: clamp, then cap with hysteresis on the last port temperature
  always_comb begin
    lim_clip = lim;
    if (lim_clip >= OneMaxS) begin
      lim_clip = OneMaxS;
    end
    if (lim_clip <= OneMinS) begin
      lim_clip = OneMinS;
    end
    set_cap  = (temp > TempSetS) && (lim_clip > CapS);
    lim_set  = set_cap ? CapS : lim_clip;
    flag_mid = flag_r | set_cap;
    keep_cap = flag_mid && (temp > TempHoldS) && (lim_set >= CapS);
  end

  always_comb begin
    res.overheat_active = flag_r;
    res.current_limit   = '0;
    unique case (count)
      2'd1: begin
        res.overheat_active = keep_cap;
        res.current_limit   = keep_cap ? bdcl_pkg::LimitW'(CapS)
                                       : bdcl_pkg::LimitW'(lim_set);
      end
      2'd2: begin
        if (lim >= TwoMaxS) begin
          res.current_limit = bdcl_pkg::LimitW'(TwoMaxS);
        end else if (lim <= TwoFloorS) begin
          res.current_limit = bdcl_pkg::LimitW'(TwoSubstS);
        end else begin
          res.current_limit = bdcl_pkg::LimitW'(lim);
        end
      end
      2'd3: begin
        if (lim >= ThreeMaxS) begin
          res.current_limit = bdcl_pkg::LimitW'(ThreeMaxS);
        end else if (lim <= ThreeMinS) begin
          res.current_limit = bdcl_pkg::LimitW'(ThreeMinS);
        end else begin
          res.current_limit = bdcl_pkg::LimitW'(lim);
        end
      end
      default: begin
        res.current_limit = '0;
      end
    endcase
  end

endmodule
